// File: rtl/core/assert_macros.svh
// assertion macros for the checker file cppc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/cppc_pkg.sv
// types and constants of the current pi controller with pwm output
package cppc_pkg;

  // mode register codes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_PWM   = 3'd1;
  localparam logic [2:0] MODE_TEST  = 3'd2;
  localparam logic [2:0] MODE_HOLD  = 3'd3;
  localparam logic [2:0] MODE_TRACK = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_DUTY  = 2'd1;
  localparam logic [1:0] REG_PGAIN = 2'd2;
  localparam logic [1:0] REG_IGAIN = 2'd3;

  localparam logic [15:0] PGAIN_RST = 16'd256;
  localparam logic [15:0] IGAIN_RST = 16'd2560;

  // full drive in q8 percent, split as a power of two times an odd factor
  localparam int FULL_SCALE_Q8 = 25600;
  localparam int SCALE_SHIFT   = 10;
  localparam int SCALE_ODD     = 25;
  localparam int MAG_W         = 15;

  localparam logic signed [7:0] DUTY_LIMIT  = 8'sd100;
  localparam logic signed [8:0] TEST_REF_MA = 9'sd200;
  localparam logic [4:0]        SEG_LEN     = 5'd25;

  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_PWM,
    KIND_TEST,
    KIND_LOOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [8:0]  ref_ma;
    logic               rec;
    logic               done;
  } meta_t;

endpackage

// File: rtl/core/current_pi_pwm_controller.sv
// current pi controller with pwm compare output, top level
//
// in channel: one word per control tick, measured and commanded current.
// out channel: one word per input word, compare count, direction pin level
//   and test reference in tdata; tuser flags a test record sample, tlast
//   the last sample of a test run.
// cfg channel: register writes, always ready; the user must write them only
//   while the block is idle (mode, open-loop duty, proportional and integral
//   gain); the block itself does not enforce this. an accepted in word passes stages
//   1 to 5 and the output register before out_tvalid. throughput: one word per cycle
//   while the skid register is empty, set by the integrator update that closes on
//   itself; the gain products, clamp and compare scaling follow in a six-register pipeline.
// stall: a skid register behind the output register takes one word while
//   out_tready is low; in_tready drops only once the skid register is full
//   and comes from a flop, with no path from out_tready.
// reset: rst_n synchronous, empties the pipeline, clears integrator, test
//   position and the test-finished flag, and loads the register defaults.
module current_pi_pwm_controller #(
  parameter int  TEST_SAMPLES = 100,
  parameter int  PWM_PERIOD   = 2400,
  localparam int CMP_W        = $clog2(PWM_PERIOD + 1),
  localparam int OUT_DW       = ((CMP_W + 10 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,     // measured_ma, target_ma
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,    // compare_value, direction, reference_ma, zero pad
  output logic              out_tuser,    // record_valid
  output logic              out_tlast,    // test_done
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int TC_W   = $clog2(TEST_SAMPLES);
  localparam int PROD_W = $clog2(cppc_pkg::FULL_SCALE_Q8 * PWM_PERIOD + 1);
  localparam int X_W    = PROD_W - cppc_pkg::SCALE_SHIFT;
  localparam int RCP_S  = X_W + 5;
  localparam int RCP_M  = (2 ** RCP_S + cppc_pkg::SCALE_ODD - 1) / cppc_pkg::SCALE_ODD;
  localparam int M_W    = $clog2(RCP_M + 1);
  localparam int QW     = (X_W + M_W > RCP_S + CMP_W) ? X_W + M_W : RCP_S + CMP_W;

  // configuration
  logic [2:0]         mode_r;
  logic signed [7:0]  duty_r;
  logic [15:0]        pgain_r;
  logic [15:0]        igain_r;

  // loop state
  logic signed [31:0] integ_r;
  logic [TC_W-1:0]    tc_r;
  logic [4:0]         seg_r;
  logic               ref_neg_r;
  logic               fin_r;

  logic en;

  // stage 1: input register
  logic               s1_vld_r;
  logic signed [15:0] s1_meas_r;
  logic signed [15:0] s1_tgt_r;

  // stage 2: error and integrator
  cppc_pkg::kind_t    kind;
  logic [2:0]         eff_mode;
  logic signed [8:0]  test_ref;
  logic signed [16:0] err;
  logic signed [32:0] sum;
  logic signed [31:0] integ_sat;
  logic               last;
  logic               s2_vld_r;
  logic signed [16:0] s2_err_r;
  logic signed [31:0] s2_integ_r;
  cppc_pkg::meta_t    s2_meta_r;

  // stage 3: gain products
  logic               s3_vld_r;
  logic signed [33:0] s3_pp_r;
  logic signed [48:0] s3_ip_r;
  cppc_pkg::meta_t    s3_meta_r;

  // stage 4: drive clamp and magnitude
  logic signed [49:0]             u;
  logic signed [49:0]             u_abs;
  logic [cppc_pkg::MAG_W-1:0]     u_mag;
  logic [6:0]                     dmag;
  logic [cppc_pkg::MAG_W-1:0]     mag_nxt;
  logic                           dir_nxt;
  logic                           s4_vld_r;
  logic [cppc_pkg::MAG_W-1:0]     s4_mag_r;
  logic                           s4_dir_r;
  cppc_pkg::meta_t                s4_meta_r;

  // stage 5: magnitude times period
  logic              s5_vld_r;
  logic [PROD_W-1:0] s5_prod_r;
  logic              s5_dir_r;
  cppc_pkg::meta_t   s5_meta_r;

  // stage 6: divide by full scale
  logic [X_W-1:0]    x;
  logic [QW-1:0]     q_full;
  logic [CMP_W-1:0]  cmp_nxt;

  // output and skid registers
  logic              out_vld_r;
  logic [CMP_W-1:0]  out_cmp_r;
  logic              out_dir_r;
  cppc_pkg::meta_t   out_meta_r;
  logic              skid_vld_r;
  logic [CMP_W-1:0]  skid_cmp_r;
  logic              skid_dir_r;
  cppc_pkg::meta_t   skid_meta_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // stage 2 logic
  always_comb begin
    eff_mode = fin_r ? cppc_pkg::MODE_IDLE : mode_r;
    unique case (eff_mode)
      cppc_pkg::MODE_PWM:   kind = cppc_pkg::KIND_PWM;
      cppc_pkg::MODE_TEST:  kind = cppc_pkg::KIND_TEST;
      cppc_pkg::MODE_HOLD,
      cppc_pkg::MODE_TRACK: kind = cppc_pkg::KIND_LOOP;
      default:              kind = cppc_pkg::KIND_IDLE;
    endcase
    test_ref = ref_neg_r ? -cppc_pkg::TEST_REF_MA : cppc_pkg::TEST_REF_MA;
    if (kind == cppc_pkg::KIND_TEST) begin
      err = 17'(s1_meas_r) - 17'(test_ref);
    end else begin
      err = 17'(s1_meas_r) - 17'(s1_tgt_r);
    end
    sum = 33'(integ_r) + 33'(err);
    if (sum[32] != sum[31]) begin
      integ_sat = sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      integ_sat = sum[31:0];
    end
    last = (tc_r == TC_W'(TEST_SAMPLES - 1));
  end

  // stage 4 logic
  always_comb begin
    u     = 50'(s3_pp_r) + 50'(s3_ip_r);
    u_abs = u[49] ? -u : u;
    if (u > 50'(cppc_pkg::FULL_SCALE_Q8) || u < -50'(cppc_pkg::FULL_SCALE_Q8)) begin
      u_mag = cppc_pkg::MAG_W'(cppc_pkg::FULL_SCALE_Q8);
    end else begin
      u_mag = u_abs[cppc_pkg::MAG_W-1:0];
    end
    if (duty_r > cppc_pkg::DUTY_LIMIT || duty_r < -cppc_pkg::DUTY_LIMIT) begin
      dmag = cppc_pkg::DUTY_LIMIT[6:0];
    end else begin
      dmag = duty_r[7] ? 7'(-duty_r) : 7'(duty_r);
    end
    unique case (s3_meta_r.kind)
      cppc_pkg::KIND_IDLE: begin
        mag_nxt = '0;
        dir_nxt = 1'b1;
      end
      cppc_pkg::KIND_PWM: begin
        mag_nxt = {dmag, 8'd0};
        dir_nxt = !duty_r[7];
      end
      cppc_pkg::KIND_TEST: begin
        mag_nxt = u_mag;
        dir_nxt = !u[49];
      end
      cppc_pkg::KIND_LOOP: begin
        mag_nxt = u_mag;
        dir_nxt = u[49];
      end
    endcase
  end

  // stage 6 logic: multiply by the reciprocal of the odd factor
  always_comb begin
    x       = s5_prod_r[PROD_W-1:cppc_pkg::SCALE_SHIFT];
    q_full  = QW'(x) * QW'(RCP_M);
    cmp_nxt = q_full[RCP_S +: CMP_W];
  end

  function automatic logic [4:0] SEG_LEN_M1();
    return cppc_pkg::SEG_LEN - 5'd1;
  endfunction

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= cppc_pkg::MODE_IDLE;
      duty_r    <= '0;
      pgain_r   <= cppc_pkg::PGAIN_RST;
      igain_r   <= cppc_pkg::IGAIN_RST;
      integ_r   <= '0;
      tc_r      <= '0;
      seg_r     <= '0;
      ref_neg_r <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      if (en && s1_vld_r) begin
        if (kind == cppc_pkg::KIND_TEST) begin
          if (last) begin
            integ_r   <= '0;
            tc_r      <= '0;
            seg_r     <= '0;
            ref_neg_r <= 1'b0;
            fin_r     <= 1'b1;
          end else begin
            integ_r <= integ_sat;
            tc_r    <= tc_r + 1'b1;
            if (seg_r == SEG_LEN_M1()) begin
              seg_r     <= '0;
              ref_neg_r <= !ref_neg_r;
            end else begin
              seg_r <= seg_r + 1'b1;
            end
          end
        end else if (kind == cppc_pkg::KIND_LOOP) begin
          integ_r <= integ_sat;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          cppc_pkg::REG_MODE: begin
            mode_r <= cfg_data[2:0];
            fin_r  <= 1'b0;
          end
          cppc_pkg::REG_DUTY:  duty_r  <= cfg_data[7:0];
          cppc_pkg::REG_PGAIN: pgain_r <= cfg_data;
          cppc_pkg::REG_IGAIN: igain_r <= cfg_data;
        endcase
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_tvalid) begin
        s1_meas_r <= in_tdata[15:0];
        s1_tgt_r  <= in_tdata[31:16];
      end
      s2_err_r          <= err;
      s2_integ_r        <= integ_sat;
      s2_meta_r.kind    <= kind;
      s2_meta_r.ref_ma  <= (kind == cppc_pkg::KIND_TEST) ? test_ref : '0;
      s2_meta_r.rec     <= (kind == cppc_pkg::KIND_TEST);
      s2_meta_r.done    <= (kind == cppc_pkg::KIND_TEST) && last;
      s3_pp_r   <= 34'($signed({1'b0, pgain_r})) * 34'(s2_err_r);
      s3_ip_r   <= 49'($signed({1'b0, igain_r})) * 49'(s2_integ_r);
      s3_meta_r <= s2_meta_r;
      s4_mag_r  <= mag_nxt;
      s4_dir_r  <= dir_nxt;
      s4_meta_r <= s3_meta_r;
      s5_prod_r <= PROD_W'(s4_mag_r) * PROD_W'(PWM_PERIOD);
      s5_dir_r  <= s4_dir_r;
      s5_meta_r <= s4_meta_r;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_tready) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= en && s5_vld_r;
        end
      end else if (!out_vld_r) begin
        out_vld_r <= en && s5_vld_r;
      end else if (en && s5_vld_r) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && out_tready && skid_vld_r) begin
      out_cmp_r  <= skid_cmp_r;
      out_dir_r  <= skid_dir_r;
      out_meta_r <= skid_meta_r;
    end else if ((!out_vld_r || out_tready) && en && s5_vld_r) begin
      out_cmp_r  <= cmp_nxt;
      out_dir_r  <= s5_dir_r;
      out_meta_r <= s5_meta_r;
    end
    if (out_vld_r && !out_tready && en && s5_vld_r) begin
      skid_cmp_r  <= cmp_nxt;
      skid_dir_r  <= s5_dir_r;
      skid_meta_r <= s5_meta_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DW'({out_meta_r.ref_ma, out_dir_r, out_cmp_r});
  assign out_tuser  = out_meta_r.rec;
  assign out_tlast  = out_meta_r.done;

endmodule

// File: rtl/core/cppc_checker.sv
// port-level checks of the current pi controller, bound to the top level
`include "assert_macros.svh"

module cppc_checker #(
  parameter int PWM_PERIOD = 2400,
  parameter int CMP_W      = 12,
  parameter int OUT_DW     = 24
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tuser,
  input logic              out_tlast
);

  // end of a test run is always a test record word
  `AST_IMP(a_done_in_record, out_tvalid && out_tlast, out_tuser)

  // reference and padding are zero outside a test record
  `AST_IMP(a_ref_zero_outside, out_tvalid && !out_tuser, out_tdata[OUT_DW-1:CMP_W+1] == '0)

  // compare count never exceeds the pwm period
  `AST_IMP(a_cmp_range, out_tvalid, out_tdata[CMP_W-1:0] <= CMP_W'(PWM_PERIOD))

  // a stalled word holds
  `AST_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // input backpressure only follows an output stall
  `AST_IMP(a_stall_cause, !in_tready, $past(out_tvalid && !out_tready))

endmodule

bind current_pi_pwm_controller cppc_checker #(
  .PWM_PERIOD(PWM_PERIOD),
  .CMP_W(CMP_W),
  .OUT_DW(OUT_DW)
) u_cppc_checker (.*);
